// File: rtl/fgs_pkg.sv
// Shared types, constants and rule tables for the fuzzy gain scheduler.
package fgs_pkg;

  // Classification geometry.
  localparam int CLASS_COUNT          = 7;
  localparam int MEMBERSHIP_FRAC_BITS = 16;
  localparam int CLS_W                = $clog2(CLASS_COUNT);
  localparam int SEG_COUNT            = CLASS_COUNT - 1;
  localparam int MU_W                 = MEMBERSHIP_FRAC_BITS + 1;
  localparam int IN_W                 = 16;
  localparam int MAG_W                = IN_W + 1;

  localparam logic [CLS_W-1:0] LAST_CLASS = CLS_W'(CLASS_COUNT - 1);
  localparam logic [MU_W-1:0]  MU_ONE     = MU_W'(1) << MEMBERSHIP_FRAC_BITS;
  localparam logic [MU_W-1:0]  MU_HALF    = MU_W'(1) << (MEMBERSHIP_FRAC_BITS - 1);

  // Deviation breakpoints, segment spans and reciprocals of the spans.
  localparam int BP_W      = 8;
  localparam int SPAN_W    = 6;
  localparam int NUM_W     = MEMBERSHIP_FRAC_BITS + SPAN_W;
  localparam int DIV_SHIFT = NUM_W;
  localparam int RECIP_W   = NUM_W - 4;
  localparam int PRODQ_W   = NUM_W + RECIP_W;

  localparam logic [BP_W-1:0] DEV_BP [CLASS_COUNT] = '{
    8'd0, 8'd23, 8'd49, 8'd80, 8'd111, 8'd148, 8'd195
  };
  localparam logic [SPAN_W-1:0] DEV_SPAN [SEG_COUNT] = '{
    6'd23, 6'd26, 6'd31, 6'd31, 6'd37, 6'd47
  };
  localparam logic [RECIP_W-1:0] DEV_RECIP [SEG_COUNT] = '{
    RECIP_W'((64'd1 << DIV_SHIFT) / 64'd23),
    RECIP_W'((64'd1 << DIV_SHIFT) / 64'd26),
    RECIP_W'((64'd1 << DIV_SHIFT) / 64'd31),
    RECIP_W'((64'd1 << DIV_SHIFT) / 64'd31),
    RECIP_W'((64'd1 << DIV_SHIFT) / 64'd37),
    RECIP_W'((64'd1 << DIV_SHIFT) / 64'd47)
  };

  // Change classes: breakpoints 0, 0.9, 1.8, 3.6, 5.4, 7.2, 9 against an integer
  // magnitude, so only magnitudes below nine fall inside the ramps.
  localparam int CHG_LIMIT = 9;
  localparam int CHG_IDX_W = $clog2(CHG_LIMIT);

  localparam logic [CLS_W-1:0] CHG_CLS [CHG_LIMIT] = '{
    3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd4, 3'd5
  };
  localparam logic [MU_W-1:0] CHG_MU [CHG_LIMIT] = '{
    MU_ONE,
    MU_W'(((64'd8  << MEMBERSHIP_FRAC_BITS) + 64'd4) / 64'd9),
    MU_W'(((64'd16 << MEMBERSHIP_FRAC_BITS) + 64'd9) / 64'd18),
    MU_W'(((64'd6  << MEMBERSHIP_FRAC_BITS) + 64'd9) / 64'd18),
    MU_W'(((64'd14 << MEMBERSHIP_FRAC_BITS) + 64'd9) / 64'd18),
    MU_W'(((64'd4  << MEMBERSHIP_FRAC_BITS) + 64'd9) / 64'd18),
    MU_W'(((64'd12 << MEMBERSHIP_FRAC_BITS) + 64'd9) / 64'd18),
    MU_W'(((64'd2  << MEMBERSHIP_FRAC_BITS) + 64'd9) / 64'd18),
    MU_W'(((64'd10 << MEMBERSHIP_FRAC_BITS) + 64'd9) / 64'd18)
  };

  // The speed path sees a change of zero, which sits in the middle class.
  localparam logic [CLS_W-1:0] SPEED_CHG_CLASS = CLS_W'(3);

  // Output paths.
  localparam int PATH_P     = 0;
  localparam int PATH_D     = 1;
  localparam int PATH_S     = 2;
  localparam int PATH_COUNT = 3;
  localparam int RULE_HITS  = 4;

  // Rule tables, indexed [change class][deviation class].
  localparam logic [CLS_W-1:0] TAB_P [CLASS_COUNT][CLASS_COUNT] = '{
    '{3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
    '{3'd3, 3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd0},
    '{3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1},
    '{3'd4, 3'd4, 3'd3, 3'd3, 3'd2, 3'd1, 3'd1},
    '{3'd4, 3'd4, 3'd4, 3'd3, 3'd2, 3'd2, 3'd1},
    '{3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd3, 3'd2},
    '{3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd3, 3'd3}
  };
  localparam logic [CLS_W-1:0] TAB_D [CLASS_COUNT][CLASS_COUNT] = '{
    '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6},
    '{3'd3, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5},
    '{3'd2, 3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd5},
    '{3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd4, 3'd5},
    '{3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3},
    '{3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3},
    '{3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2}
  };
  localparam logic [CLS_W-1:0] TAB_S [CLASS_COUNT][CLASS_COUNT] = '{
    '{3'd5, 3'd5, 3'd6, 3'd6, 3'd4, 3'd3, 3'd2},
    '{3'd4, 3'd4, 3'd6, 3'd6, 3'd3, 3'd2, 3'd1},
    '{3'd4, 3'd4, 3'd5, 3'd5, 3'd3, 3'd2, 3'd1},
    '{3'd3, 3'd4, 3'd5, 3'd5, 3'd2, 3'd1, 3'd1},
    '{3'd3, 3'd3, 3'd4, 3'd4, 3'd2, 3'd1, 3'd0},
    '{3'd3, 3'd2, 3'd3, 3'd4, 3'd1, 3'd1, 3'd0},
    '{3'd3, 3'd2, 3'd2, 3'd4, 3'd1, 3'd0, 3'd0}
  };

  // Singleton output values in unsigned Q.8.
  localparam int SING_W = 18;
  localparam logic [SING_W-1:0] SING [PATH_COUNT][CLASS_COUNT] = '{
    '{SING_W'(3251), SING_W'(3328), SING_W'(3430), SING_W'(3533),
      SING_W'(3661), SING_W'(3789), SING_W'(3891)},
    '{SING_W'(500 * 256), SING_W'(524 * 256), SING_W'(554 * 256), SING_W'(584 * 256),
      SING_W'(620 * 256), SING_W'(656 * 256), SING_W'(689 * 256)},
    '{SING_W'(600 * 256), SING_W'(620 * 256), SING_W'(640 * 256), SING_W'(660 * 256),
      SING_W'(680 * 256), SING_W'(700 * 256), SING_W'(720 * 256)}
  };

  // Accumulation and defuzzification widths.
  localparam int WPROD_W  = 2 * MU_W;
  localparam int ACC_W    = MEMBERSHIP_FRAC_BITS + 3;
  localparam int PROD_W   = ACC_W + SING_W;
  localparam int SUM_W    = PROD_W + 3;
  localparam int SCALED_W = SUM_W - MEMBERSHIP_FRAC_BITS;
  localparam int LO_COUNT = 4;

  localparam logic [SUM_W-1:0] SUM_HALF = SUM_W'(1) << (MEMBERSHIP_FRAC_BITS - 1);

  localparam int GAIN_P_W = 12;
  localparam int GAIN_W   = 18;
  localparam logic [SCALED_W-1:0] GAIN_MAX [PATH_COUNT] = '{
    SCALED_W'((1 << GAIN_P_W) - 1),
    SCALED_W'((1 << GAIN_W) - 1),
    SCALED_W'((1 << GAIN_W) - 1)
  };

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OCC_W       = QCNT_W + 1;

  // One classified sample as it crosses the queue.
  typedef struct packed {
    logic [CLS_W-1:0] dev_cls;
    logic [MU_W-1:0]  dev_mu;
    logic [CLS_W-1:0] chg_cls;
    logic [MU_W-1:0]  chg_mu;
  } fgs_item_t;

  // Queue fill status seen by both halves.
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              not_empty;
  } fgs_q_status_t;

endpackage

// File: rtl/fuzzy_gain_scheduler_core.sv
// A result passes the front stages, the queue and the back stages to the output register.
// Throughput: one transfer per cycle in both directions while the output is not stalled.
// The front keeps at most 4 samples between its two stages and the queue, which bounds
// how far it runs ahead of a stalled back end.
// Reset clears only the valid flags and the queue pointers and count; data is not reset.
module fuzzy_gain_scheduler_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [fgs_pkg::IN_W-1:0]   position_i,
  input  logic signed [fgs_pkg::IN_W-1:0]   position_change_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fgs_pkg::GAIN_P_W-1:0]      gain_p_o,
  output logic [fgs_pkg::GAIN_W-1:0]        gain_d_o,
  output logic [fgs_pkg::GAIN_W-1:0]        speed_target_o
);
  import fgs_pkg::*;

  logic          push;
  logic          pop;
  fgs_item_t     push_item;
  fgs_item_t     pop_item;
  fgs_q_status_t q_status;

  // Classifying front end.
  fgs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .position_i        (position_i),
    .position_change_i (position_change_i),
    .q_status_i        (q_status),
    .push_o            (push),
    .item_o            (push_item)
  );

  // Decoupling queue.
  fgs_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (pop_item),
    .status_o (q_status)
  );

  // Rule evaluation and defuzzification back end.
  fgs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (pop_item),
    .q_status_i     (q_status),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .gain_p_o       (gain_p_o),
    .gain_d_o       (gain_d_o),
    .speed_target_o (speed_target_o)
  );

endmodule

// File: rtl/fgs_front.sv
// Front end: takes input transfers, forms magnitudes, classes and memberships.
module fgs_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [fgs_pkg::IN_W-1:0]   position_i,
  input  logic signed [fgs_pkg::IN_W-1:0]   position_change_i,
  input  fgs_pkg::fgs_q_status_t            q_status_i,
  output logic                              push_o,
  output fgs_pkg::fgs_item_t                item_o
);
  import fgs_pkg::*;

  logic                accept;
  logic [MAG_W-1:0]    dev_mag;
  logic [MAG_W-1:0]    chg_mag;
  logic [CLS_W-1:0]    dev_cls;
  logic [SPAN_W-1:0]   dev_diff;
  logic [CLS_W-1:0]    chg_cls;
  logic [MU_W-1:0]     chg_mu;
  logic [OCC_W-1:0]    occupancy;

  logic                s1_valid_q;
  logic [CLS_W-1:0]    s1_cls_q;
  logic [SPAN_W-1:0]   s1_diff_q;
  logic [CLS_W-1:0]    s1_chg_cls_q;
  logic [MU_W-1:0]     s1_chg_mu_q;

  logic [CLS_W-1:0]    s1_span_idx;
  logic [NUM_W-1:0]    s1_num;
  logic [PRODQ_W-1:0]  s1_prod;

  logic                s2_valid_q;
  logic [CLS_W-1:0]    s2_cls_q;
  logic [NUM_W-1:0]    s2_num_q;
  logic [MU_W-1:0]     s2_q0_q;
  logic [CLS_W-1:0]    s2_chg_cls_q;
  logic [MU_W-1:0]     s2_chg_mu_q;

  logic [CLS_W-1:0]    s2_span_idx;
  logic [NUM_W-1:0]    s2_span;
  logic [NUM_W-1:0]    s2_rem;
  logic [MU_W-1:0]     s2_mu;

  // Admit a new sample only while the queue can hold everything in flight.
  assign occupancy  = OCC_W'(q_status_i.count) + OCC_W'(s1_valid_q) + OCC_W'(s2_valid_q);
  assign in_stall_o = occupancy >= OCC_W'(QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  // Magnitudes of the two signed inputs; the most negative value maps to 2^15.
  assign dev_mag = position_i[IN_W-1] ? (MAG_W'(1) << IN_W) - {1'b0, position_i}
                                      : {1'b0, position_i};
  assign chg_mag = position_change_i[IN_W-1]
                 ? (MAG_W'(1) << IN_W) - {1'b0, position_change_i}
                 : {1'b0, position_change_i};

  // Deviation segment search: the first breakpoint above the magnitude wins.
  always_comb begin
    dev_cls  = LAST_CLASS;
    dev_diff = '0;
    for (int k = SEG_COUNT; k >= 1; k--) begin
      if (dev_mag < MAG_W'(DEV_BP[k])) begin
        dev_cls  = CLS_W'(k - 1);
        dev_diff = SPAN_W'(DEV_BP[k] - dev_mag[BP_W-1:0]);
      end
    end
  end

  // Change classification is a small lookup since only nine magnitudes ramp.
  always_comb begin
    if (chg_mag < MAG_W'(CHG_LIMIT)) begin
      chg_cls = CHG_CLS[chg_mag[CHG_IDX_W-1:0]];
      chg_mu  = CHG_MU[chg_mag[CHG_IDX_W-1:0]];
    end else begin
      chg_cls = LAST_CLASS;
      chg_mu  = MU_ONE;
    end
  end

  // Stage one registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cls_q     <= dev_cls;
    s1_diff_q    <= dev_diff;
    s1_chg_cls_q <= chg_cls;
    s1_chg_mu_q  <= chg_mu;
  end

  // Reciprocal estimate of the rounded membership quotient.
  assign s1_span_idx = (s1_cls_q == LAST_CLASS) ? '0 : s1_cls_q;
  assign s1_num      = {s1_diff_q, {MEMBERSHIP_FRAC_BITS{1'b0}}}
                     + NUM_W'(DEV_SPAN[s1_span_idx] >> 1);
  assign s1_prod     = PRODQ_W'(s1_num) * PRODQ_W'(DEV_RECIP[s1_span_idx]);

  // Stage two registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_cls_q     <= s1_cls_q;
    s2_num_q     <= s1_num;
    s2_q0_q      <= s1_prod[DIV_SHIFT +: MU_W];
    s2_chg_cls_q <= s1_chg_cls_q;
    s2_chg_mu_q  <= s1_chg_mu_q;
  end

  // The estimate is at most one low; one remainder check corrects it.
  assign s2_span_idx = (s2_cls_q == LAST_CLASS) ? '0 : s2_cls_q;
  assign s2_span     = NUM_W'(DEV_SPAN[s2_span_idx]);
  assign s2_rem      = s2_num_q - NUM_W'(s2_q0_q) * s2_span;

  always_comb begin
    if (s2_cls_q == LAST_CLASS) begin
      s2_mu = MU_ONE;
    end else if (s2_rem >= s2_span) begin
      s2_mu = s2_q0_q + MU_W'(1);
    end else begin
      s2_mu = s2_q0_q;
    end
  end

  // Hand the classified sample to the queue.
  assign push_o         = s2_valid_q;
  assign item_o.dev_cls = s2_cls_q;
  assign item_o.dev_mu  = s2_mu;
  assign item_o.chg_cls = s2_chg_cls_q;
  assign item_o.chg_mu  = s2_chg_mu_q;

`ifndef SYNTHESIS
  a_mu_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (item_o.dev_mu <= MU_ONE))
    else $error("deviation membership exceeds one");

  a_edge_mu_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && (item_o.dev_cls == LAST_CLASS)) |-> (item_o.dev_mu == MU_ONE))
    else $error("edge class membership is not one");
`endif

endmodule

// File: rtl/fgs_queue.sv
// Short queue that decouples the classifying front from the rule back end.
module fgs_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  fgs_pkg::fgs_item_t     item_i,
  input  logic                   pop_i,
  output fgs_pkg::fgs_item_t     item_o,
  output fgs_pkg::fgs_q_status_t status_o
);
  import fgs_pkg::*;

  fgs_item_t          slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q;
  logic [QPTR_W-1:0]  wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q;
  logic [QPTR_W-1:0]  rd_ptr_d;
  logic [QCNT_W-1:0]  count_q;
  logic [QCNT_W-1:0]  count_d;

  // Pointer advance with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o             = slot_q[rd_ptr_q];
  assign status_o.count     = count_q;
  assign status_o.not_empty = (count_q != '0);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < QCNT_W'(QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");

  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (count_q == QCNT_W'($past(count_q) + QCNT_W'($past(push_i))
                                  - QCNT_W'($past(pop_i)))))
    else $error("queue count out of step with transfers");
`endif

endmodule

// File: rtl/fgs_back.sv
// Back end: rule weights, class accumulation, defuzzification and output register.
module fgs_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  fgs_pkg::fgs_item_t              item_i,
  input  fgs_pkg::fgs_q_status_t          q_status_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [fgs_pkg::GAIN_P_W-1:0]    gain_p_o,
  output logic [fgs_pkg::GAIN_W-1:0]      gain_d_o,
  output logic [fgs_pkg::GAIN_W-1:0]      speed_target_o
);
  import fgs_pkg::*;

  logic                 advance;

  logic [MU_W-1:0]      mu_dev [2];
  logic [MU_W-1:0]      mu_chg [2];
  logic [MU_W-1:0]      weight_d [PATH_COUNT][RULE_HITS];
  logic [CLS_W-1:0]     class_d  [PATH_COUNT][RULE_HITS];
  logic [ACC_W-1:0]     acc_d    [PATH_COUNT][CLASS_COUNT];
  logic [PROD_W-1:0]    prod_d   [PATH_COUNT][CLASS_COUNT];
  logic [SUM_W-1:0]     lo_d     [PATH_COUNT];
  logic [SUM_W-1:0]     hi_d     [PATH_COUNT];
  logic [SCALED_W-1:0]  sat_d    [PATH_COUNT];

  logic                 b1_valid_q;
  logic [MU_W-1:0]      b1_weight_q [PATH_COUNT][RULE_HITS];
  logic [CLS_W-1:0]     b1_class_q  [PATH_COUNT][RULE_HITS];
  logic                 b2_valid_q;
  logic [ACC_W-1:0]     b2_acc_q    [PATH_COUNT][CLASS_COUNT];
  logic                 b3_valid_q;
  logic [PROD_W-1:0]    b3_prod_q   [PATH_COUNT][CLASS_COUNT];
  logic                 b4_valid_q;
  logic [SUM_W-1:0]     b4_lo_q     [PATH_COUNT];
  logic [SUM_W-1:0]     b4_hi_q     [PATH_COUNT];
  logic                 out_valid_q;
  logic [GAIN_P_W-1:0]  gain_p_q;
  logic [GAIN_W-1:0]    gain_d_q;
  logic [GAIN_W-1:0]    speed_q;

  // The whole back pipeline moves unless a finished result is held.
  assign advance = !out_valid_q || !out_stall_i;
  assign pop_o   = advance && q_status_i.not_empty;

  // Rule weights for the four neighbor cells and their output classes.
  always_comb begin
    mu_dev[0] = item_i.dev_mu;
    mu_dev[1] = MU_ONE - item_i.dev_mu;
    mu_chg[0] = item_i.chg_mu;
    mu_chg[1] = MU_ONE - item_i.chg_mu;
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 2; a++) begin
        logic               dev_ok;
        logic               chg_ok;
        logic [CLS_W-1:0]   ie;
        logic [CLS_W-1:0]   ic;
        logic [WPROD_W-1:0] wprod;
        dev_ok = (a == 0) || (item_i.dev_cls != LAST_CLASS);
        chg_ok = (b == 0) || (item_i.chg_cls != LAST_CLASS);
        ie     = item_i.dev_cls + CLS_W'(a);
        ic     = item_i.chg_cls + CLS_W'(b);
        wprod  = WPROD_W'(mu_dev[a]) * WPROD_W'(mu_chg[b]) + WPROD_W'(MU_HALF);
        weight_d[PATH_P][2*b+a] = '0;
        weight_d[PATH_D][2*b+a] = '0;
        weight_d[PATH_S][2*b+a] = '0;
        class_d[PATH_P][2*b+a]  = '0;
        class_d[PATH_D][2*b+a]  = '0;
        class_d[PATH_S][2*b+a]  = '0;
        if (dev_ok && chg_ok) begin
          weight_d[PATH_P][2*b+a] = wprod[MEMBERSHIP_FRAC_BITS +: MU_W];
          weight_d[PATH_D][2*b+a] = wprod[MEMBERSHIP_FRAC_BITS +: MU_W];
          class_d[PATH_P][2*b+a]  = TAB_P[ic][ie];
          class_d[PATH_D][2*b+a]  = TAB_D[ic][ie];
        end
        // The speed path has full membership in its fixed change class.
        if (dev_ok && (b == 0)) begin
          weight_d[PATH_S][2*b+a] = mu_dev[a];
          class_d[PATH_S][2*b+a]  = TAB_S[SPEED_CHG_CLASS][ie];
        end
      end
    end
  end

  // Per-class accumulation of the rule weights.
  always_comb begin
    for (int p = 0; p < PATH_COUNT; p++) begin
      for (int k = 0; k < CLASS_COUNT; k++) begin
        logic [ACC_W-1:0] sum;
        sum = '0;
        for (int j = 0; j < RULE_HITS; j++) begin
          if (b1_class_q[p][j] == CLS_W'(k)) begin
            sum = sum + ACC_W'(b1_weight_q[p][j]);
          end
        end
        acc_d[p][k] = sum;
      end
    end
  end

  // Class weight times singleton value.
  always_comb begin
    for (int p = 0; p < PATH_COUNT; p++) begin
      for (int k = 0; k < CLASS_COUNT; k++) begin
        prod_d[p][k] = PROD_W'(b2_acc_q[p][k]) * PROD_W'(SING[p][k]);
      end
    end
  end

  // Two partial sums of the products.
  always_comb begin
    for (int p = 0; p < PATH_COUNT; p++) begin
      lo_d[p] = '0;
      hi_d[p] = '0;
      for (int k = 0; k < CLASS_COUNT; k++) begin
        if (k < LO_COUNT) begin
          lo_d[p] = lo_d[p] + SUM_W'(b3_prod_q[p][k]);
        end else begin
          hi_d[p] = hi_d[p] + SUM_W'(b3_prod_q[p][k]);
        end
      end
    end
  end

  // Final sum, round half up, scale and saturate.
  always_comb begin
    for (int p = 0; p < PATH_COUNT; p++) begin
      logic [SUM_W-1:0] total;
      total    = b4_lo_q[p] + b4_hi_q[p] + SUM_HALF;
      sat_d[p] = total[SUM_W-1:MEMBERSHIP_FRAC_BITS];
      if (sat_d[p] > GAIN_MAX[p]) begin
        sat_d[p] = GAIN_MAX[p];
      end
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      b4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      b1_valid_q  <= pop_o;
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      b4_valid_q  <= b3_valid_q;
      out_valid_q <= b4_valid_q;
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      b1_weight_q <= weight_d;
      b1_class_q  <= class_d;
      b2_acc_q    <= acc_d;
      b3_prod_q   <= prod_d;
      b4_lo_q     <= lo_d;
      b4_hi_q     <= hi_d;
      gain_p_q    <= sat_d[PATH_P][GAIN_P_W-1:0];
      gain_d_q    <= sat_d[PATH_D][GAIN_W-1:0];
      speed_q     <= sat_d[PATH_S][GAIN_W-1:0];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign gain_p_o       = gain_p_q;
  assign gain_d_o       = gain_d_q;
  assign speed_target_o = speed_q;

endmodule

// File: sim/tb_fuzzy_gain_scheduler_core.sv
// Self-checking testbench for fuzzy_gain_scheduler_core: random traffic against a local gain predictor.
module tb_fuzzy_gain_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fgs_pkg::IN_W;
  import fgs_pkg::GAIN_P_W;
  import fgs_pkg::GAIN_W;

  // Scheduler geometry as seen by the predictor.
  localparam int              CLASSES   = 7;
  localparam int              FRAC      = 16;
  localparam longint unsigned MU_UNIT   = 64'd1 << FRAC;
  localparam longint unsigned MU_ROUND  = 64'd1 << (FRAC - 1);
  localparam int unsigned     SPEED_CHG = 3;
  localparam longint unsigned KP_CEIL   = (64'd1 << GAIN_P_W) - 1;
  localparam longint unsigned WIDE_CEIL = (64'd1 << GAIN_W) - 1;

  localparam int DIRECTED_COUNT = 24;
  localparam int RANDOM_COUNT   = 1426;
  localparam int SETTLE_CYCLES  = 20;

  // Directed samples: zero, breakpoints and their neighbors, every change ramp, extremes.
  localparam int DIRECTED_POS [DIRECTED_COUNT] = '{0, 1, -1, 22, 23, 24, -48, 49, 79, 80,
                                                   -111, 147, 148, 194, -195, 196, 32767,
                                                   -32767, -32768, -32768, 0, 12, 100, -170};
  localparam int DIRECTED_CHG [DIRECTED_COUNT] = '{0, 1, -1, 9, 8, -2, 3, -4, 5, -6, 7, -8,
                                                   9, 10, 0, -1, 32767, -32767, -32768, 0,
                                                   -32768, 4, 2, -6};

  typedef enum int {PATH_KP, PATH_KD, PATH_SPEED} gain_path_e;
  typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} flow_style_e;

  // Class breakpoints: deviation in counts, change in tenths of a count.
  localparam int unsigned DEV_EDGES [CLASSES] = '{0, 23, 49, 80, 111, 148, 195};
  localparam int unsigned CHG_EDGES_TENTHS [CLASSES] = '{0, 9, 18, 36, 54, 72, 90};

  // Rule tables per output path, indexed [change class][deviation class].
  localparam int unsigned RULE [3][CLASSES][CLASSES] = '{
    '{'{2, 2, 1, 1, 1, 0, 0}, '{3, 3, 2, 1, 1, 1, 0}, '{4, 3, 3, 2, 2, 1, 1},
      '{4, 4, 3, 3, 2, 1, 1}, '{4, 4, 4, 3, 2, 2, 1}, '{5, 5, 5, 4, 4, 3, 2},
      '{6, 6, 5, 5, 4, 3, 3}},
    '{'{3, 3, 4, 5, 5, 6, 6}, '{3, 3, 4, 4, 5, 5, 5}, '{2, 3, 3, 4, 5, 5, 5},
      '{1, 2, 2, 3, 3, 4, 5}, '{1, 1, 2, 2, 3, 3, 3}, '{0, 1, 1, 1, 2, 2, 3},
      '{0, 0, 1, 1, 1, 2, 2}},
    '{'{5, 5, 6, 6, 4, 3, 2}, '{4, 4, 6, 6, 3, 2, 1}, '{4, 4, 5, 5, 3, 2, 1},
      '{3, 4, 5, 5, 2, 1, 1}, '{3, 3, 4, 4, 2, 1, 0}, '{3, 2, 3, 4, 1, 1, 0},
      '{3, 2, 2, 4, 1, 0, 0}}
  };

  // Output singletons in unsigned Q.8.
  localparam longint unsigned SINGLETON [3][CLASSES] = '{
    '{3251, 3328, 3430, 3533, 3661, 3789, 3891},
    '{500 * 256, 524 * 256, 554 * 256, 584 * 256, 620 * 256, 656 * 256, 689 * 256},
    '{600 * 256, 620 * 256, 640 * 256, 660 * 256, 680 * 256, 700 * 256, 720 * 256}
  };

  typedef struct {
    logic signed [IN_W-1:0] position;
    logic signed [IN_W-1:0] change;
    bit                     drain_first;
  } sample_t;

  typedef struct packed {
    logic [GAIN_P_W-1:0] kp;
    logic [GAIN_W-1:0]   kd;
    logic [GAIN_W-1:0]   speed;
  } gains_t;

  typedef struct {
    gains_t                 gains;
    logic signed [IN_W-1:0] position;
    logic signed [IN_W-1:0] change;
  } expected_t;

  logic                   clk_i             = 1'b0;
  logic                   rst_ni            = 1'b0;
  logic                   in_valid_i        = 1'b0;
  logic signed [IN_W-1:0] position_i        = '0;
  logic signed [IN_W-1:0] position_change_i = '0;
  logic                   out_stall_i       = 1'b0;
  logic                   in_stall_o;
  logic                   out_valid_o;
  logic [GAIN_P_W-1:0]    gain_p_o;
  logic [GAIN_W-1:0]      gain_d_o;
  logic [GAIN_W-1:0]      speed_target_o;

  sample_t     pending_samples [$];
  expected_t   expected_gains  [$];
  int          total_samples    = 0;
  int          samples_accepted = 0;
  int          gains_checked    = 0;
  int          mismatch_count   = 0;
  int          burst_left       = 0;
  int          gap_left         = 0;
  int          flow_span        = 0;
  flow_style_e flow_style       = FLOW_FREE;

  fuzzy_gain_scheduler_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .position_i        (position_i),
    .position_change_i (position_change_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .gain_p_o          (gain_p_o),
    .gain_d_o          (gain_d_o),
    .speed_target_o    (speed_target_o)
  );

  // Clock.
  always #10 clk_i = ~clk_i;

  // Magnitude of a 16-bit two's complement value; the most negative one gives 32768.
  function automatic int unsigned magnitude(input logic [IN_W-1:0] raw);
    int unsigned v;
    v = 32'(raw);
    if (v >= 32768) v = 65536 - v;
    return v;
  endfunction

  // Finds the segment that holds x and its two memberships, rounded half up.
  function automatic void place_on_scale(input int unsigned edges [CLASSES],
                                         input int unsigned x,
                                         output int unsigned cls,
                                         output longint unsigned mu_near,
                                         output longint unsigned mu_far);
    longint unsigned span;
    cls     = CLASSES - 1;
    mu_near = MU_UNIT;
    mu_far  = 0;
    for (int k = CLASSES - 1; k >= 1; k--) begin
      if (x < edges[k]) begin
        span    = edges[k] - edges[k-1];
        mu_near = ((longint'(edges[k] - x) << FRAC) + span / 2) / span;
        mu_far  = MU_UNIT - mu_near;
        cls     = k - 1;
      end
    end
  endfunction

  // Weights the up to four rule hits of one path and defuzzifies them with saturation.
  function automatic longint unsigned blend_path(input gain_path_e path,
                                                 input int unsigned dev_cls,
                                                 input longint unsigned dev_mu0,
                                                 input longint unsigned dev_mu1,
                                                 input int unsigned chg_cls,
                                                 input longint unsigned chg_mu0,
                                                 input longint unsigned chg_mu1,
                                                 input longint unsigned ceiling);
    longint unsigned class_weight [CLASSES];
    longint unsigned dev_mu [2];
    longint unsigned chg_mu [2];
    longint unsigned total;
    int unsigned     di;
    int unsigned     ci;
    dev_mu = '{dev_mu0, dev_mu1};
    chg_mu = '{chg_mu0, chg_mu1};
    total  = 0;
    for (int k = 0; k < CLASSES; k++) class_weight[k] = 0;
    for (int b = 0; b < 2; b++) begin
      for (int a = 0; a < 2; a++) begin
        di = dev_cls + a;
        ci = chg_cls + b;
        if (di < CLASSES && ci < CLASSES) begin
          class_weight[RULE[int'(path)][ci][di]] += (dev_mu[a] * chg_mu[b] + MU_ROUND) >> FRAC;
        end
      end
    end
    for (int k = 0; k < CLASSES; k++) total += class_weight[k] * SINGLETON[int'(path)][k];
    total = (total + MU_ROUND) >> FRAC;
    return (total > ceiling) ? ceiling : total;
  endfunction

  // Expected kp, kd and speed setpoint for one control sample.
  function automatic gains_t predict_gains(input logic [IN_W-1:0] position,
                                           input logic [IN_W-1:0] change);
    gains_t          g;
    int unsigned     dev_cls;
    int unsigned     chg_cls;
    longint unsigned dev_mu0;
    longint unsigned dev_mu1;
    longint unsigned chg_mu0;
    longint unsigned chg_mu1;
    place_on_scale(DEV_EDGES, magnitude(position), dev_cls, dev_mu0, dev_mu1);
    place_on_scale(CHG_EDGES_TENTHS, magnitude(change) * 10, chg_cls, chg_mu0, chg_mu1);
    g.kp    = GAIN_P_W'(blend_path(PATH_KP, dev_cls, dev_mu0, dev_mu1,
                                   chg_cls, chg_mu0, chg_mu1, KP_CEIL));
    g.kd    = GAIN_W'(blend_path(PATH_KD, dev_cls, dev_mu0, dev_mu1,
                                 chg_cls, chg_mu0, chg_mu1, WIDE_CEIL));
    // The speed path always sees a zero change, fully in the middle class.
    g.speed = GAIN_W'(blend_path(PATH_SPEED, dev_cls, dev_mu0, dev_mu1,
                                 SPEED_CHG, MU_UNIT, 0, WIDE_CEIL));
    return g;
  endfunction

  // Random sample: mostly inside the ramps, some near breakpoints, some over the full range.
  function automatic sample_t draw_sample();
    sample_t     s;
    int unsigned pos_mag;
    int unsigned chg_mag;
    bit          raw_bits;
    raw_bits      = 1'b0;
    s.drain_first = 1'b0;
    pos_mag       = 0;
    chg_mag       = 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        pos_mag = $urandom_range(0, 220);
        chg_mag = $urandom_range(0, 12);
      end
      6, 7: begin
        pos_mag = DEV_EDGES[$urandom_range(1, CLASSES - 1)] + $urandom_range(0, 4) - 2;
        chg_mag = $urandom_range(0, 10);
      end
      8: begin
        raw_bits   = 1'b1;
        s.position = IN_W'($urandom);
        s.change   = IN_W'($urandom);
      end
      default: begin
        pos_mag = $urandom_range(0, 32768);
        chg_mag = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 32768) : $urandom_range(0, 9);
      end
    endcase
    if (!raw_bits) begin
      s.position = IN_W'(($urandom_range(0, 1) == 1) ? -int'(pos_mag) : int'(pos_mag));
      s.change   = IN_W'(($urandom_range(0, 1) == 1) ? -int'(chg_mag) : int'(chg_mag));
    end
    return s;
  endfunction

  // One line per mismatch, and the count goes up.
  task automatic note_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Driver: bursts of transfers with random gaps, holding the payload while stalled.
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t   next_sample;
    expected_t want;
    bit        launch;
    if (!rst_ni) begin
      in_valid_i        <= 1'b0;
      position_i        <= '0;
      position_change_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        want.gains    = predict_gains(position_i, position_change_i);
        want.position = position_i;
        want.change   = position_change_i;
        expected_gains.push_back(want);
        samples_accepted++;
      end
      if (!in_valid_i || !in_stall_o) begin
        launch = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_samples.size() > 0 &&
                     !(pending_samples[0].drain_first && expected_gains.size() > 0)) begin
          launch = 1'b1;
        end
        if (launch) begin
          next_sample        = pending_samples.pop_front();
          position_i        <= next_sample.position;
          position_change_i <= next_sample.change;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_valid_i <= launch;
      end
    end
  end

  // Monitor: checks each result transfer and drives the output stall pattern.
  always @(posedge clk_i or negedge rst_ni) begin
    expected_t want;
    bit        next_stall;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        gains_checked++;
        if (expected_gains.size() == 0) begin
          note_mismatch($sformatf("result kp=%0d kd=%0d speed=%0d with nothing outstanding",
                                  gain_p_o, gain_d_o, speed_target_o));
        end else begin
          want = expected_gains.pop_front();
          if (gain_p_o !== want.gains.kp)
            note_mismatch($sformatf("kp got %0d want %0d (pos %0d chg %0d)", gain_p_o,
                                    want.gains.kp, want.position, want.change));
          if (gain_d_o !== want.gains.kd)
            note_mismatch($sformatf("kd got %0d want %0d (pos %0d chg %0d)", gain_d_o,
                                    want.gains.kd, want.position, want.change));
          if (speed_target_o !== want.gains.speed)
            note_mismatch($sformatf("speed got %0d want %0d (pos %0d chg %0d)", speed_target_o,
                                    want.gains.speed, want.position, want.change));
        end
      end
      // Stall style changes every so often: free flow, light, heavy or alternating.
      if (flow_span == 0) begin
        flow_style = flow_style_e'($urandom_range(0, 3));
        flow_span  = $urandom_range(8, 120);
      end else begin
        flow_span--;
      end
      case (flow_style)
        FLOW_FREE:  next_stall = 1'b0;
        FLOW_LIGHT: next_stall = ($urandom_range(0, 4) == 0);
        FLOW_HEAVY: next_stall = ($urandom_range(0, 3) != 0);
        default:    next_stall = ~out_stall_i;
      endcase
      out_stall_i <= next_stall;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    sample_t s;
    // Directed part: zero, breakpoints and their neighbors, every change ramp, extremes.
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      s.position    = IN_W'(DIRECTED_POS[i]);
      s.change      = IN_W'(DIRECTED_CHG[i]);
      s.drain_first = 1'b0;
      pending_samples.push_back(s);
    end
    // Random part; the sender lets the block run dry before a few of these.
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      s = draw_sample();
      s.drain_first = (i % 400 == 0);
      pending_samples.push_back(s);
    end
    total_samples = pending_samples.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (samples_accepted < total_samples || expected_gains.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d samples: %0d directed edge cases, the rest random near breakpoints",
             total_samples, DIRECTED_COUNT);
    $display("and over the full input range; %0d gain results checked, %0d mismatches.",
             gains_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("Timeout with %0d of %0d samples accepted.", samples_accepted, total_samples);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// File: filelist.f
rtl/fgs_pkg.sv
rtl/fgs_front.sv
rtl/fgs_queue.sv
rtl/fgs_back.sv
rtl/fuzzy_gain_scheduler_core.sv
sim/tb_fuzzy_gain_scheduler_core.sv
